### rtl/core/fsfp_pkg.sv
// ----------------------------------------------------------------------------
// fsfp_pkg
// Shared types and constants for the flow sensor frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package fsfp_pkg;

    // Frame header and length bytes
    localparam logic [7:0] HDR_SYNC  = 8'hDF;
    localparam logic [7:0] HDR_DEV   = 8'h14;
    localparam logic [7:0] HDR_SYS   = 8'h00;
    localparam logic [7:0] HDR_MSG   = 8'h55;
    localparam logic [7:0] LEN_BYTE  = 8'h12;

    // Payload bytes per frame and bytes kept for decode
    localparam int unsigned FRAME_LEN   = 18;
    localparam int unsigned KEEP_BYTES  = 14;
    localparam int unsigned COUNT_W     = 5;
    localparam int unsigned STORE_IDX_W = $clog2(KEEP_BYTES);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_DEV,
        PH_SYS,
        PH_MSG,
        PH_SEQ,
        PH_LEN,
        PH_DATA,
        PH_CSUM
    } phase_t;

    typedef logic [7:0] store_t [KEEP_BYTES];

    typedef struct packed {
        logic        [31:0] device_time_ms;
        logic signed [15:0] flow_vx;
        logic signed [15:0] flow_vy;
        logic        [15:0] flow_quality;
        logic        [15:0] range_mm;
        logic               range_valid;
    } fields_t;

endpackage

`default_nettype wire

### rtl/core/fsfp_fields.sv
// ----------------------------------------------------------------------------
// fsfp_fields
// Decodes the kept payload bytes into the result fields: little-endian time, flow and range, quality as a byte product.
// ----------------------------------------------------------------------------
`default_nettype none

module fsfp_fields
    import fsfp_pkg::*;
(
    input  wire logic [7:0] store [KEEP_BYTES],
    output fields_t         fields
);

    logic [15:0] quality_prod;

    assign quality_prod = {8'd0, store[8]} * {8'd0, store[9]};

    always_comb
    begin
        fields.device_time_ms = {store[3], store[2], store[1], store[0]};
        fields.flow_vx        = {store[5], store[4]};
        fields.flow_vy        = {store[7], store[6]};
        fields.flow_quality   = quality_prod;
        fields.range_mm       = {store[11], store[10]};
        fields.range_valid    = (store[13] == 8'd1);
    end

endmodule

`default_nettype wire

### rtl/core/flow_sensor_frame_parser_top.sv
// ----------------------------------------------------------------------------
// flow_sensor_frame_parser_top
// Byte-stream parser for flow / time-of-flight sensor frames.
// ----------------------------------------------------------------------------
// The block takes one received byte per transfer and emits one decoded result
// for each frame whose 8-bit additive checksum matches; bad frames and bytes
// outside a frame produce nothing. It sustains one byte per clock cycle while
// no result waits for out_ready: each byte sits in an input register and goes
// through the parse step, and a finished frame lands in the result register,
// so its checksum byte passes both registers before the result appears. The
// input register keeps taking bytes while a result waits for out_ready, until
// it holds one byte itself. No clearing pass is needed after reset.
`default_nettype none

module flow_sensor_frame_parser_top
    import fsfp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic        [7:0]  rx_byte,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic             [31:0] device_time_ms,
    output logic signed      [15:0] flow_vx,
    output logic signed      [15:0] flow_vy,
    output logic             [15:0] flow_quality,
    output logic             [15:0] range_mm,
    output logic                    range_valid
);

    logic                 in_v_reg, in_v_next;
    logic [7:0]           in_byte_reg;
    logic                 out_v_reg, out_v_next;
    fields_t              res_reg;
    phase_t               phase_reg, phase_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [7:0]           sum_reg, sum_next;
    logic [7:0]           store_reg [KEEP_BYTES];

    logic                 advance;
    logic                 store_we;
    logic                 emit;
    logic                 fixed_ok;
    logic                 data_done;
    logic [COUNT_W-1:0]   count_inc;
    logic [7:0]           b;
    fields_t              fields;

    assign b         = in_byte_reg;
    assign advance   = in_v_reg && (!out_v_reg || out_ready);
    assign in_ready  = !in_v_reg || advance;
    assign count_inc = count_reg + COUNT_W'(1);
    assign data_done = (count_inc >= COUNT_W'(FRAME_LEN)) || (count_inc == '0);

    // Fixed byte expected in the current header phase
    always_comb
    begin
        case (phase_reg)
            PH_DEV:  fixed_ok = (b == HDR_DEV);
            PH_SYS:  fixed_ok = (b == HDR_SYS);
            PH_MSG:  fixed_ok = (b == HDR_MSG);
            PH_LEN:  fixed_ok = (b == LEN_BYTE);
            default: fixed_ok = 1'b0;
        endcase
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (advance)
        begin
            case (phase_reg)
                PH_HUNT: if (b == HDR_SYNC) phase_next = PH_DEV;
                PH_DEV:  phase_next = fixed_ok ? PH_SYS  : PH_HUNT;
                PH_SYS:  phase_next = fixed_ok ? PH_MSG  : PH_HUNT;
                PH_MSG:  phase_next = fixed_ok ? PH_SEQ  : PH_HUNT;
                PH_SEQ:  phase_next = PH_LEN;
                PH_LEN:  phase_next = fixed_ok ? PH_DATA : PH_HUNT;
                PH_DATA: if (data_done) phase_next = PH_CSUM;
                PH_CSUM: phase_next = PH_HUNT;
                default: phase_next = PH_HUNT;
            endcase
        end
    end

    // Sum, count, store write and result emit
    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        store_we   = 1'b0;
        emit       = 1'b0;
        if (advance)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (b == HDR_SYNC) sum_next = b;
                end
                PH_DEV, PH_SYS, PH_MSG, PH_LEN:
                begin
                    if (fixed_ok) sum_next = sum_reg + b;
                end
                PH_SEQ:
                begin
                    sum_next = sum_reg + b;
                end
                PH_DATA:
                begin
                    store_we   = (count_reg < COUNT_W'(KEEP_BYTES));
                    count_next = data_done ? '0 : count_inc;
                    sum_next   = sum_reg + b;
                end
                PH_CSUM:
                begin
                    emit = (sum_reg == b);
                end
                default:
                begin
                    sum_next = sum_reg;
                end
            endcase
        end
    end

    // Input register and result valid
    always_comb
    begin
        in_v_next = in_ready ? in_valid : in_v_reg;
        out_v_next = out_ready ? 1'b0 : out_v_reg;
        if (advance && emit)
            out_v_next = 1'b1;
    end

    fsfp_fields u_fields (
        .store  (store_reg),
        .fields (fields)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            phase_reg <= PH_HUNT;
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            in_v_reg  <= in_v_next;
            out_v_reg <= out_v_next;
            phase_reg <= phase_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_byte_reg <= rx_byte;
        if (store_we)
            store_reg[count_reg[STORE_IDX_W-1:0]] <= b;
        if (advance && emit)
            res_reg <= fields;
    end

    assign out_valid      = out_v_reg;
    assign device_time_ms = res_reg.device_time_ms;
    assign flow_vx        = res_reg.flow_vx;
    assign flow_vy        = res_reg.flow_vy;
    assign flow_quality   = res_reg.flow_quality;
    assign range_mm       = res_reg.range_mm;
    assign range_valid    = res_reg.range_valid;

endmodule

`default_nettype wire

### rtl/core/fsfp_checker.sv
// ----------------------------------------------------------------------------
// fsfp_checker
// Port-level checks for the flow sensor frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

module fsfp_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic        [31:0] device_time_ms,
    input wire logic signed [15:0] flow_vx,
    input wire logic signed [15:0] flow_vy,
    input wire logic        [15:0] flow_quality,
    input wire logic        [15:0] range_mm,
    input wire logic               range_valid
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(device_time_ms)
            && $stable(flow_vx) && $stable(flow_vy) && $stable(flow_quality)
            && $stable(range_mm) && $stable(range_valid))
        else $error("result changed while stalled");

    // With no result pending the input side never stalls
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    // A byte taken during an output stall fills the input register
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && $past(out_valid && !out_ready)
            && $past(in_valid && in_ready) |-> !in_ready)
        else $error("input accepted beyond buffer during stall");

    // Quality is a product of two bytes
    a_quality_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> flow_quality <= 16'd65025)
        else $error("quality out of range");

endmodule

bind flow_sensor_frame_parser_top fsfp_checker u_fsfp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .device_time_ms (device_time_ms),
    .flow_vx        (flow_vx),
    .flow_vy        (flow_vy),
    .flow_quality   (flow_quality),
    .range_mm       (range_mm),
    .range_valid    (range_valid)
);

`default_nettype wire
